// ===== rtl/core/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg: shared definitions for the set-associative LRU write-back cache
// Geometry constants, line-state record and controller state type.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int BLOCK_BYTES = 32;
    localparam int SETS        = 64;
    localparam int WAYS        = 4;

    localparam int ADDR_W   = 32;
    localparam int OFF_W    = $clog2(BLOCK_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W    = WAY_W;

    // stream payload widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
    } t_way;

    localparam int ROW_W = $bits(t_way) * WAYS;

    typedef t_way [WAYS-1:0] t_row;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

// ===== rtl/core/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram: single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on contents.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/set_assoc_lru_writeback_cache.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache: tag/state engine of a write-back cache
// Set-associative lookup with true-LRU ages, write-allocate, victim report.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one access request per transfer, byte address in
//   tdata and the write flag in tuser. Output stream (m_axis): one result per
//   request with hit, eviction flag, block address and dirty bit of the
//   displaced line.
//   Each set is one row of a RAM (all ways together). A request reads its row
//   at acceptance, then a single tag/age compare unit walks the ways, one way
//   per cycle, then the updated row is written back and the result loaded
//   into the output register. tready is high only between requests. The output
//   register lets the next request be taken while a result waits; if the
//   receiver stalls, the following request holds in its write-back cycle
//   until the output register frees up.
//   Reset clears all per-set row-valid flags at once, so every line reads
//   as invalid, clean and age zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [31:0] addr
    input  logic [salc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [0] is_write
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] hit, [1] evicted, [33:2] evict_address, [34] evict_dirty, [39:35] zero
    output logic [salc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    import salc_pkg::*;

    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

    t_state r_state, n_state;

    logic             in_acc;
    logic             scan_en;
    logic             upd_go;
    logic             out_free;
    logic [IDX_W-1:0] in_set;

    logic [TAG_W-1:0] r_tag;
    logic [IDX_W-1:0] r_set;
    logic             r_wr;
    logic             r_row_ok;
    logic [SETS-1:0]  r_set_ok;

    logic [WAY_W-1:0] r_way;
    logic             r_hit_found;
    logic [WAY_W-1:0] r_hit_way;
    logic             r_free_found;
    logic [WAY_W-1:0] r_free_way;
    logic [WAY_W-1:0] r_vic_way;
    logic [AGE_W-1:0] r_vic_age;

    logic [ROW_W-1:0] ram_rdata;
    t_row             row;
    t_row             new_row;
    t_way             cur;
    logic [WAY_W-1:0] sel;
    logic             was_valid;
    logic [AGE_W-1:0] sel_age;
    logic             res_evicted;
    logic             res_dirty;
    logic [ADDR_W-1:0] res_addr;
    logic [WAYS-1:0]  row_valid;

    logic              r_out_valid;
    logic              r_out_hit;
    logic              r_out_evicted;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_dirty;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_set   = (SET_BITS > 0) ? IDX_W'(i_s_axis_tdata[ADDR_W-1:0] >> OFF_W) : '0;

    // ---------------- controller ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_way == LAST_WAY) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        scan_en         = 1'b0;
        upd_go          = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_s_axis_tready = 1'b1;
            ST_SCAN:   scan_en = 1'b1;
            ST_UPDATE: upd_go = out_free;
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- set row storage ----------------
    salc_ram #(
        .WIDTH  (ROW_W),
        .ADDR_W (IDX_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (upd_go),
        .i_waddr (r_set),
        .i_wdata (new_row),
        .i_re    (in_acc),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // a set never written since reset reads as all-invalid
    assign row = r_row_ok ? t_row'(ram_rdata) : t_row'('0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_ok <= '0;
        end else if (upd_go) begin
            r_set_ok[r_set] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tag    <= TAG_W'(i_s_axis_tdata[ADDR_W-1:0] >> (OFF_W + SET_BITS));
            r_set    <= in_set;
            r_wr     <= i_s_axis_tuser;
            r_row_ok <= r_set_ok[in_set];
        end
    end

    // ---------------- way scan, one way per cycle ----------------
    assign cur = row[r_way];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_way        <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (scan_en) begin
            r_way <= r_way + 1'b1;
            if (cur.valid && cur.tag == r_tag && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_way   <= r_way;
            end
            if (!cur.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_way   <= r_way;
            end
            // strict compare keeps the lowest way on an age tie
            if (r_way == '0 || cur.age > r_vic_age) begin
                r_vic_age <= cur.age;
                r_vic_way <= r_way;
            end
        end
    end

    // ---------------- row update and result ----------------
    always_comb begin
        sel       = r_hit_found ? r_hit_way : (r_free_found ? r_free_way : r_vic_way);
        was_valid = r_hit_found || !r_free_found;
        sel_age   = row[sel].age;
        for (int i = 0; i < WAYS; i++) begin
            new_row[i]   = row[i];
            row_valid[i] = row[i].valid;
            if (WAY_W'(i) == sel) begin
                new_row[i].tag   = r_hit_found ? row[i].tag : r_tag;
                new_row[i].valid = 1'b1;
                new_row[i].dirty = r_hit_found ? (row[i].dirty | r_wr) : r_wr;
                new_row[i].age   = '0;
            end else if (row[i].valid && (!was_valid || row[i].age < sel_age)) begin
                new_row[i].age = row[i].age + 1'b1;
            end
        end
        res_evicted = !r_hit_found && !r_free_found;
        res_dirty   = res_evicted && row[sel].dirty;
        res_addr    = '0;
        if (res_evicted) begin
            res_addr = (ADDR_W'(row[sel].tag) << (OFF_W + SET_BITS))
                     | ((SET_BITS > 0) ? (ADDR_W'(r_set) << OFF_W) : '0);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_out_hit     <= r_hit_found;
            r_out_evicted <= res_evicted;
            r_out_addr    <= res_addr;
            r_out_dirty   <= res_dirty;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_dirty, r_out_addr, r_out_evicted, r_out_hit};

    // ---------------- assertions ----------------
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_SCAN && r_way == '0))
        else $error("accepted request did not start the way scan");

    a_victim_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && !r_hit_found && !r_free_found) |-> (&row_valid))
        else $error("replacement chosen while an invalid way exists");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_evicted))
        else $error("result reports both hit and eviction");

    a_dirty_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_dirty |-> r_out_evicted)
        else $error("dirty write-back flagged without an eviction");

    a_write_marks_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> (r_set_ok[$past(r_set)] && r_out_valid))
        else $error("row write-back did not mark the set or load the result");

endmodule

// ===== tb/tb_set_assoc_lru_writeback_cache.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_writeback_cache: regression for the cache tag/state engine
// Drives read/write access requests over the input stream. A local copy of the
// tags, valid, dirty and true-LRU ages predicts hit, victim address and dirty
// flag for each request. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_writeback_cache;
    import salc_pkg::*;

    localparam int LINES     = SETS * WAYS;
    localparam int TAG_POOL  = 6;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [31:0] evict_address;
        logic        evict_dirty;
    } t_lookup_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // [31:0] addr
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    // [0] is_write
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [0] hit, [1] evicted, [33:2] evict_address, [34] evict_dirty, [39:35] zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // predicted line state, index = set * WAYS + way
    logic [TAG_W-1:0] line_tag   [LINES];
    bit               line_valid [LINES];
    bit               line_dirty [LINES];
    logic [AGE_W-1:0] line_age   [LINES];

    t_lookup_result lookup_results_q [$];
    t_lookup_result got_result;
    t_lookup_result want_result;

    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;

    set_assoc_lru_writeback_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // make way w most recent; an invalid way counts as older than all valid ways
    function automatic void age_touch(int unsigned base, int unsigned w, bit was_valid);
        logic [AGE_W-1:0] a;
        a = line_age[base + w];
        for (int unsigned i = 0; i < WAYS; i++) begin
            if (i != w && line_valid[base + i]) begin
                if (!was_valid || line_age[base + i] < a)
                    line_age[base + i] = line_age[base + i] + 1'b1;
            end
        end
        line_age[base + w] = '0;
    endfunction

    function automatic t_lookup_result predict_lookup(input logic [31:0] addr, input logic wr);
        int unsigned      set_idx;
        int unsigned      base;
        int unsigned      victim;
        bit               found_free;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] oldest;
        t_lookup_result   r;
        set_idx = (addr / BLOCK_BYTES) % SETS;
        tag     = TAG_W'(addr / (BLOCK_BYTES * SETS));
        base    = set_idx * WAYS;
        r       = '0;
        for (int unsigned w = 0; w < WAYS; w++) begin
            if (line_valid[base + w] && line_tag[base + w] == tag) begin
                if (wr)
                    line_dirty[base + w] = 1'b1;
                age_touch(base, w, 1'b1);
                r.hit = 1'b1;
                return r;
            end
        end
        found_free = 1'b0;
        victim     = 0;
        for (int unsigned w = 0; w < WAYS; w++) begin
            if (!found_free && !line_valid[base + w]) begin
                victim     = w;
                found_free = 1'b1;
            end
        end
        if (found_free) begin
            age_touch(base, victim, 1'b0);
        end else begin
            // lowest way wins a tie on the greatest age
            oldest = line_age[base];
            for (int unsigned w = 1; w < WAYS; w++) begin
                if (line_age[base + w] > oldest) begin
                    oldest = line_age[base + w];
                    victim = w;
                end
            end
            r.evicted       = 1'b1;
            r.evict_dirty   = line_dirty[base + victim];
            r.evict_address = (32'(line_tag[base + victim]) * SETS + set_idx) * BLOCK_BYTES;
            age_touch(base, victim, 1'b1);
        end
        line_tag[base + victim]   = tag;
        line_valid[base + victim] = 1'b1;
        line_dirty[base + victim] = wr;
        return r;
    endfunction

    function automatic logic [31:0] make_addr(int unsigned tag, int unsigned set_idx,
                                              int unsigned off);
        return 32'(tag * (BLOCK_BYTES * SETS) + set_idx * BLOCK_BYTES + off);
    endfunction

    task automatic report_mismatch(string what, logic [39:0] want, logic [39:0] got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch %0d at %0t: %s expected 0x%0h got 0x%0h",
                     mismatches, $realtime, what, want, got);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_result.hit           = o_m_axis_tdata[0];
            got_result.evicted       = o_m_axis_tdata[1];
            got_result.evict_address = o_m_axis_tdata[33:2];
            got_result.evict_dirty   = o_m_axis_tdata[34];
            if (lookup_results_q.size() == 0) begin
                report_mismatch("unexpected result", '0, o_m_axis_tdata);
            end else begin
                want_result = lookup_results_q.pop_front();
                if (got_result.hit !== want_result.hit)
                    report_mismatch("hit", want_result.hit, got_result.hit);
                if (got_result.evicted !== want_result.evicted)
                    report_mismatch("evicted", want_result.evicted, got_result.evicted);
                if (got_result.evict_address !== want_result.evict_address)
                    report_mismatch("evict_address", want_result.evict_address,
                                    got_result.evict_address);
                if (got_result.evict_dirty !== want_result.evict_dirty)
                    report_mismatch("evict_dirty", want_result.evict_dirty,
                                    got_result.evict_dirty);
                if (o_m_axis_tdata[39:35] !== 5'd0)
                    report_mismatch("pad bits", '0, o_m_axis_tdata[39:35]);
            end
        end
    end

    // called and returns at a falling edge; tvalid stays high into the next call
    task automatic send_request(input logic [31:0] addr, input logic wr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= addr;
        i_s_axis_tuser  <= wr;
        do @(posedge i_clk); while (!o_s_axis_tready);
        lookup_results_q.insert(lookup_results_q.size(), predict_lookup(addr, wr));
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        while (lookup_results_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // address extremes
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b1);
        send_request(32'h0000_001F, 1'b0);
        send_request(32'hFFFF_FFE0, 1'b0);
        // fill all ways of one set, then hits, then LRU victims dirty and clean
        send_request(make_addr(1, 5, 0), 1'b0);
        send_request(make_addr(2, 5, 3), 1'b1);
        send_request(make_addr(3, 5, 31), 1'b0);
        send_request(make_addr(4, 5, 8), 1'b1);
        send_request(make_addr(1, 5, 4), 1'b0);
        send_request(make_addr(3, 5, 0), 1'b1);
        send_request(make_addr(5, 5, 0), 1'b0);
        send_request(make_addr(6, 5, 0), 1'b1);
        send_request(make_addr(7, 5, 0), 1'b0);
        send_request(make_addr(3, 5, 0), 1'b0);
        // push the max-tag line out of the top set
        for (int t = 1; t <= WAYS; t++)
            send_request(make_addr(t, SETS - 1, 0), 1'b0);
    endtask

    task automatic test_random_traffic(int n, int s_idle, int r_idle);
        int unsigned tags [TAG_POOL];
        int unsigned base_set;
        logic [31:0] addr;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        base_set = $urandom_range(SETS - 4);
        foreach (tags[i])
            tags[i] = $urandom_range((1 << TAG_W) - 1);
        for (int k = 0; k < n; k++) begin
            // mostly a few hot sets with a small tag pool so hits and evictions mix
            if ($urandom_range(99) < 75)
                addr = make_addr(tags[$urandom_range(TAG_POOL - 1)],
                                 base_set + $urandom_range(3),
                                 $urandom_range(BLOCK_BYTES - 1));
            else
                addr = $urandom;
            send_request(addr, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_drain_pause();
        test_random_traffic(12, 15, 66);
        wait_results_drained();
        test_random_traffic(12, 15, 66);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        mismatches      = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        for (int i = 0; i < LINES; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_age[i]   = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_drain_pause();
        test_random_traffic(640, 15, 66);
        test_random_traffic(640, 66, 15);
        test_random_traffic(640, 0, 0);

        wait_results_drained();
        repeat (4 * WAYS + 8) @(negedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
